// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the checker files.
// Each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/tss_pkg.sv -----
// ----------------------------------------------------------------------------
// tss_pkg
// Shared widths, action codes and types of the tone segment sequencer.
// ----------------------------------------------------------------------------
package tss_pkg;

   localparam int SEG_SLOTS        = 5;
   localparam int DEF_NUM_SEGMENTS = 5;
   localparam int FREQ_W           = 16;
   localparam int DUR_W            = 16;
   localparam int TIME_W           = 32;
   localparam int ACTION_W         = 2;

   localparam logic [ACTION_W-1:0] ACT_TONE    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SILENCE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_START = 1'b1;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [DUR_W-1:0]  dur;
   } seg_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/tss_cell.sv -----
// ----------------------------------------------------------------------------
// tss_cell
// One stage of the segment chain: holds a pending segment and its live bit,
// loads in parallel on a start and shifts towards the head on each step.
// ----------------------------------------------------------------------------
module tss_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  tss_pkg::cell_ctrl_type ctrl,
   input  tss_pkg::seg_type       load_seg,
   input  logic                   load_tail_any,
   output logic                   load_any,
   input  tss_pkg::seg_type       next_seg,
   input  logic                   next_live,
   output tss_pkg::seg_type       seg,
   output logic                   live
);
   import tss_pkg::*;

   seg_type seg_ff;
   seg_type seg_in;
   logic    live_ff;
   logic    live_in;

   // live on load if this or any later segment has a nonzero duration
   assign load_any = (load_seg.dur != '0) | load_tail_any;

   always_comb begin
      seg_in  = seg_ff;
      live_in = live_ff;
      if (ctrl.load) begin
         seg_in  = load_seg;
         live_in = load_any;
      end else if (ctrl.shift) begin
         seg_in  = next_seg;
         live_in = next_live;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
      end
   end

   assign seg  = seg_ff;
   assign live = live_ff;

endmodule

// ----- rtl/core/tone_segment_sequencer.sv -----
// ----------------------------------------------------------------------------
// tone_segment_sequencer
// Buzzer sequence player: a start item loads a segment list and plays the
// first segment, tick items step through the rest and end with a release.
// ----------------------------------------------------------------------------
// A result item is registered in the output register, or first parked in
// the one-item skid stage, before it appears on rsp_. Throughput: one item
// per cycle while req_stall is low; the step is one 32-bit compare and add
// on the chain head. req_stall rises only while the skid stage holds an item.
// Reset (synchronous): playback stops, chain live bits and deadline clear;
// segment payload is not cleared and is never read before a start loads it.
module tone_segment_sequencer #(
   parameter int NUM_SEGMENTS = tss_pkg::DEF_NUM_SEGMENTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [tss_pkg::TIME_W-1:0]    req_now_ms,
   input  logic [tss_pkg::FREQ_W-1:0]    req_freq_a,
   input  logic [tss_pkg::DUR_W-1:0]     req_dur_a,
   input  logic [tss_pkg::FREQ_W-1:0]    req_freq_b,
   input  logic [tss_pkg::DUR_W-1:0]     req_dur_b,
   input  logic [tss_pkg::FREQ_W-1:0]    req_freq_c,
   input  logic [tss_pkg::DUR_W-1:0]     req_dur_c,
   input  logic [tss_pkg::FREQ_W-1:0]    req_freq_d,
   input  logic [tss_pkg::DUR_W-1:0]     req_dur_d,
   input  logic [tss_pkg::FREQ_W-1:0]    req_freq_e,
   input  logic [tss_pkg::DUR_W-1:0]     req_dur_e,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tss_pkg::ACTION_W-1:0]  rsp_action,
   output logic [tss_pkg::FREQ_W-1:0]    rsp_tone_freq,
   output logic [tss_pkg::DUR_W-1:0]     rsp_tone_dur
);
   import tss_pkg::*;

   // segments as carried by the request item
   seg_type req_seg [SEG_SLOTS];

   // chain wiring; the extra entry past the tail is tied off
   seg_type       cell_seg  [NUM_SEGMENTS+1];
   logic          cell_live [NUM_SEGMENTS+1];
   logic          cell_any  [NUM_SEGMENTS+1];
   seg_type       cell_load [NUM_SEGMENTS];
   cell_ctrl_type ctrl;

   // playback state
   logic              active_ff;
   logic              active_in;
   logic [TIME_W-1:0] deadline_ff;
   logic [TIME_W-1:0] deadline_in;

   // result of the current item, before the output register
   logic                res_valid;
   logic                res_release;
   logic [ACTION_W-1:0] res_action;
   seg_type             res_seg;

   // output register and skid stage
   logic                out_valid_ff;
   logic                out_valid_in;
   logic [ACTION_W-1:0] out_action_ff;
   logic [ACTION_W-1:0] out_action_in;
   seg_type             out_seg_ff;
   seg_type             out_seg_in;
   logic                skid_valid_ff;
   logic                skid_valid_in;
   logic [ACTION_W-1:0] skid_action_ff;
   logic [ACTION_W-1:0] skid_action_in;
   seg_type             skid_seg_ff;
   seg_type             skid_seg_in;

   logic req_fire;
   logic out_take;
   logic start_any;

   always_comb begin
      req_seg[0] = '{freq: req_freq_a, dur: req_dur_a};
      req_seg[1] = '{freq: req_freq_b, dur: req_dur_b};
      req_seg[2] = '{freq: req_freq_c, dur: req_dur_c};
      req_seg[3] = '{freq: req_freq_d, dur: req_dur_d};
      req_seg[4] = '{freq: req_freq_e, dur: req_dur_e};
   end

   // --- segment chain -------------------------------------------------------
   // Cell g holds the segment that follows the head by g+1 places. On a start
   // segment 0 goes out at once, so cell g loads request segment g+1.
   assign cell_seg[NUM_SEGMENTS]  = '0;
   assign cell_live[NUM_SEGMENTS] = 1'b0;
   assign cell_any[NUM_SEGMENTS]  = 1'b0;

   for (genvar g = 0; g < NUM_SEGMENTS; g++) begin : g_cell
      if (g + 1 < NUM_SEGMENTS) begin : g_load
         assign cell_load[g] = req_seg[g+1];
      end else begin : g_tail
         assign cell_load[g] = '0;
      end

      tss_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .load_seg      (cell_load[g]),
         .load_tail_any (cell_any[g+1]),
         .load_any      (cell_any[g]),
         .next_seg      (cell_seg[g+1]),
         .next_live     (cell_live[g+1]),
         .seg           (cell_seg[g]),
         .live          (cell_live[g])
      );
   end

   // --- step logic ----------------------------------------------------------
   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid & ~skid_valid_ff;
   assign out_take  = out_valid_ff & ~rsp_stall;

   // any nonzero duration in the new list means playback starts
   assign start_any = (req_seg[0].dur != '0) | cell_any[0];

   always_comb begin
      res_valid   = 1'b0;
      res_release = 1'b0;
      res_seg     = '0;
      ctrl        = '0;
      active_in   = active_ff;
      deadline_in = deadline_ff;
      if (req_fire) begin
         if (req_type == REQ_START) begin
            // list is stored even when all durations are zero
            ctrl.load = 1'b1;
            active_in = start_any;
            if (start_any) begin
               res_valid   = 1'b1;
               res_seg     = req_seg[0];
               deadline_in = req_now_ms + TIME_W'(req_seg[0].dur);
            end
         end else if (active_ff && (req_now_ms >= deadline_ff)) begin
            res_valid = 1'b1;
            if (cell_live[0]) begin
               res_seg     = cell_seg[0];
               ctrl.shift  = 1'b1;
               deadline_in = req_now_ms + TIME_W'(cell_seg[0].dur);
            end else begin
               // list exhausted: release and stop
               res_release = 1'b1;
               active_in   = 1'b0;
            end
         end
      end
   end

   always_comb begin
      if (res_release) begin
         res_action = ACT_RELEASE;
      end else if (res_seg.freq != '0) begin
         res_action = ACT_TONE;
      end else begin
         res_action = ACT_SILENCE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         deadline_ff <= '0;
      end else begin
         active_ff   <= active_in;
         deadline_ff <= deadline_in;
      end
   end

   // --- output register and skid --------------------------------------------
   // A result arriving while the output item is stalled parks in the skid
   // stage; requests stall until it has moved up.
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_action_in  = out_action_ff;
      out_seg_in     = out_seg_ff;
      skid_valid_in  = skid_valid_ff;
      skid_action_in = skid_action_ff;
      skid_seg_in    = skid_seg_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_in  = 1'b1;
            out_action_in = skid_action_ff;
            out_seg_in    = skid_seg_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_in  = res_valid;
         out_action_in = res_action;
         out_seg_in    = res_seg;
      end else if (res_valid) begin
         skid_valid_in  = 1'b1;
         skid_action_in = res_action;
         skid_seg_in    = res_seg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_action_ff  <= out_action_in;
      out_seg_ff     <= out_seg_in;
      skid_action_ff <= skid_action_in;
      skid_seg_ff    <= skid_seg_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_action    = out_action_ff;
   assign rsp_tone_freq = out_seg_ff.freq;
   assign rsp_tone_dur  = out_seg_ff.dur;

endmodule

// ----- rtl/core/tss_checker.sv -----
// ----------------------------------------------------------------------------
// tss_checker
// Port-level checks on the tone segment sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tss_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [tss_pkg::ACTION_W-1:0]  rsp_action,
   input logic [tss_pkg::FREQ_W-1:0]    rsp_tone_freq,
   input logic [tss_pkg::DUR_W-1:0]     rsp_tone_dur
);
   import tss_pkg::*;

   `ASSERT_IMPLY(a_action_legal, clock, reset, rsp_valid, rsp_action == ACT_TONE || rsp_action == ACT_SILENCE || rsp_action == ACT_RELEASE, "illegal action code")
   `ASSERT_IMPLY(a_release_zero, clock, reset, rsp_valid && rsp_action == ACT_RELEASE, rsp_tone_freq == '0 && rsp_tone_dur == '0, "release item carries data")
   `ASSERT_IMPLY(a_freq_matches, clock, reset, rsp_valid && rsp_action != ACT_RELEASE, (rsp_tone_freq != '0) == (rsp_action == ACT_TONE), "action disagrees with frequency")
   `ASSERT_IMPLY(a_stall_busy, clock, reset, req_stall, rsp_valid, "request stalled with empty output")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_action) && $stable(rsp_tone_freq) && $stable(rsp_tone_dur), "stalled item changed")

endmodule

bind tone_segment_sequencer tss_checker u_tss_checker (.*);

// ----- tb/sv/tone_sequence_checker.sv -----
// ----------------------------------------------------------------------------
// tone_sequence_checker
// Watches both channels of the tone segment sequencer. Every accepted request
// item drives a private copy of the player, which queues the tone, silence
// or release it expects. Every accepted result item is compared with the
// oldest queued one.
// ----------------------------------------------------------------------------
module tone_sequence_checker #(
   parameter int NUM_SEGMENTS = tss_pkg::DEF_NUM_SEGMENTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_type,
   input  logic [tss_pkg::TIME_W-1:0]    req_now_ms,
   input  logic [tss_pkg::FREQ_W-1:0]    req_freq_a,
   input  logic [tss_pkg::DUR_W-1:0]     req_dur_a,
   input  logic [tss_pkg::FREQ_W-1:0]    req_freq_b,
   input  logic [tss_pkg::DUR_W-1:0]     req_dur_b,
   input  logic [tss_pkg::FREQ_W-1:0]    req_freq_c,
   input  logic [tss_pkg::DUR_W-1:0]     req_dur_c,
   input  logic [tss_pkg::FREQ_W-1:0]    req_freq_d,
   input  logic [tss_pkg::DUR_W-1:0]     req_dur_d,
   input  logic [tss_pkg::FREQ_W-1:0]    req_freq_e,
   input  logic [tss_pkg::DUR_W-1:0]     req_dur_e,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [tss_pkg::ACTION_W-1:0]  rsp_action,
   input  logic [tss_pkg::FREQ_W-1:0]    rsp_tone_freq,
   input  logic [tss_pkg::DUR_W-1:0]     rsp_tone_dur,
   output int                            mismatches,
   output int                            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import tss_pkg::*;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [FREQ_W-1:0]   freq;
      logic [DUR_W-1:0]    dur;
   } tone_event_type;

   tone_event_type    due_tones [$];
   seg_type           stored_seg [SEG_SLOTS];
   logic [2:0]        seq_len;
   logic [2:0]        next_pos;
   logic [TIME_W-1:0] due_time;
   int                miss_total = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t tone check: %s got %0h want %0h", $realtime, what, got, want);
      miss_total++;
   endtask

   // one step of the player: nothing while idle or early, else next segment,
   // or the release once the list is used up
   task automatic step_player(input logic [TIME_W-1:0] now);
      tone_event_type ev;
      if (seq_len == 0 || now < due_time)
         return;
      if (next_pos < seq_len) begin
         ev.freq   = stored_seg[next_pos].freq;
         ev.dur    = stored_seg[next_pos].dur;
         ev.action = (ev.freq != 0) ? ACT_TONE : ACT_SILENCE;
         due_time  = now + TIME_W'(ev.dur);
         next_pos  = next_pos + 3'd1;
      end else begin
         ev       = '0;
         ev.action = ACT_RELEASE;
         seq_len  = '0;
         next_pos = '0;
      end
      due_tones.push_back(ev);
   endtask

   task automatic load_sequence(input logic [TIME_W-1:0] now,
                                input seg_type incoming [SEG_SLOTS]);
      seq_len = '0;
      for (int i = 0; i < NUM_SEGMENTS; i++) begin
         stored_seg[i] = incoming[i];
         if (incoming[i].dur != 0)
            seq_len = 3'(i + 1);
      end
      // all durations zero: playback stops, position and deadline kept
      if (seq_len == 0)
         return;
      next_pos = '0;
      due_time = '0;
      step_player(now);
   endtask

   always @(posedge clock) begin : watch
      tone_event_type want;
      seg_type        incoming [SEG_SLOTS];
      if (reset) begin
         seq_len  = '0;
         next_pos = '0;
         due_time = '0;
         due_tones.delete();
      end else begin
         // result side first: a result never belongs to a request of this edge
         if (rsp_valid && !rsp_stall) begin
            if (due_tones.size() == 0) begin
               report_mismatch("result with nothing due, action", 32'(rsp_action), '0);
            end else begin
               want = due_tones.pop_front();
               if (rsp_action != want.action)
                  report_mismatch("action", 32'(rsp_action), 32'(want.action));
               if (rsp_tone_freq != want.freq)
                  report_mismatch("tone_freq", 32'(rsp_tone_freq), 32'(want.freq));
               if (rsp_tone_dur != want.dur)
                  report_mismatch("tone_dur", 32'(rsp_tone_dur), 32'(want.dur));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_type == REQ_START) begin
               incoming[0] = {req_freq_a, req_dur_a};
               incoming[1] = {req_freq_b, req_dur_b};
               incoming[2] = {req_freq_c, req_dur_c};
               incoming[3] = {req_freq_d, req_dur_d};
               incoming[4] = {req_freq_e, req_dur_e};
               load_sequence(req_now_ms, incoming);
            end else begin
               step_player(req_now_ms);
            end
         end
      end
      mismatches  <= miss_total;
      outstanding <= due_tones.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the tone segment sequencer. A directed opening
// covers idle and early ticks, empty lists, restarts and deadline wrap; then
// random segment lists are played out by ticks, mixed with noise, under
// random idling on both sides, a long result hold-off and drain pauses.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tss_pkg::*;

   localparam int NUM_SEGMENTS = DEF_NUM_SEGMENTS;
   localparam int RANDOM_ITEMS = 1500;
   localparam int HOLD_CYCLES  = 300;   // long result hold-off
   localparam int QUIET_LIMIT  = 5000;  // cycles with no item moving

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_type;
   logic [TIME_W-1:0]   req_now_ms;
   logic [FREQ_W-1:0]   req_freq_a, req_freq_b, req_freq_c, req_freq_d, req_freq_e;
   logic [DUR_W-1:0]    req_dur_a, req_dur_b, req_dur_c, req_dur_d, req_dur_e;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [ACTION_W-1:0] rsp_action;
   logic [FREQ_W-1:0]   rsp_tone_freq;
   logic [DUR_W-1:0]    rsp_tone_dur;

   int fail_count;
   int pending;

   // shared between the sender and receiver processes
   logic calm;           // no idling on either side while set
   logic hold_req;       // sender asks the receiver for one long hold-off
   logic hold_taken;     // owned by the receiver

   seg_type           seg_buf [SEG_SLOTS];   // segment fields of next item
   logic [TIME_W-1:0] now_ms_cur;
   int                items_sent;
   int                quiet_cycles = 0;

   tone_segment_sequencer #(.NUM_SEGMENTS(NUM_SEGMENTS)) u_dut (.*);

   tone_sequence_checker #(.NUM_SEGMENTS(NUM_SEGMENTS)) u_checker (
      .*,
      .mismatches  (fail_count),
      .outstanding (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Sender helpers
   // ------------------------------------------------------------------

   // Offers one item; random idle cycles in front unless calm. Returns at
   // the edge that accepted it, with valid still high.
   task automatic offer_item(input logic kind, input logic [TIME_W-1:0] now);
      while (!calm && $urandom_range(0, 99) < 26) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_type   <= kind;
      req_now_ms <= now;
      req_freq_a <= seg_buf[0].freq;
      req_dur_a  <= seg_buf[0].dur;
      req_freq_b <= seg_buf[1].freq;
      req_dur_b  <= seg_buf[1].dur;
      req_freq_c <= seg_buf[2].freq;
      req_dur_c  <= seg_buf[2].dur;
      req_freq_d <= seg_buf[3].freq;
      req_dur_d  <= seg_buf[3].dur;
      req_freq_e <= seg_buf[4].freq;
      req_dur_e  <= seg_buf[4].dur;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic set_segs(input logic [15:0] f0, d0, f1, d1, f2, d2, f3, d3, f4, d4);
      seg_buf[0] = {f0, d0};
      seg_buf[1] = {f1, d1};
      seg_buf[2] = {f2, d2};
      seg_buf[3] = {f3, d3};
      seg_buf[4] = {f4, d4};
   endtask

   // full-range junk for fields the block should ignore (ticks) or for noise
   task automatic scramble_segs();
      for (int i = 0; i < SEG_SLOTS; i++)
         seg_buf[i] = {16'($urandom), 16'($urandom)};
   endtask

   task automatic send_tick(input logic [TIME_W-1:0] now);
      scramble_segs();
      offer_item(REQ_TICK, now);
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   // A start with a random list, then ticks walking time forward. Mostly
   // short durations and small steps so lists play through to the release;
   // now and then full-range durations with big jumps, or a base near wrap.
   task automatic play_random_sequence();
      logic wide;
      int   n_ticks;
      wide = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < SEG_SLOTS; i++) begin
         seg_buf[i].freq = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
         if ($urandom_range(0, 3) == 0)
            seg_buf[i].dur = 16'd0;
         else
            seg_buf[i].dur = wide ? 16'($urandom) : 16'($urandom_range(1, 20));
      end
      if ($urandom_range(0, 9) == 0)
         now_ms_cur = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
      offer_item(REQ_START, now_ms_cur);
      n_ticks = $urandom_range(3, 12);
      repeat (n_ticks) begin
         now_ms_cur += wide ? 32'($urandom_range(0, 70000)) : 32'($urandom_range(0, 25));
         send_tick(now_ms_cur);
      end
   endtask

   // random ticks, junk starts and empty starts
   task automatic inject_noise();
      case ($urandom_range(0, 2))
         0: begin
            if ($urandom_range(0, 1) == 0)
               now_ms_cur = $urandom;
            send_tick(now_ms_cur);
         end
         1: begin
            scramble_segs();
            offer_item(REQ_START, $urandom);
         end
         default: begin
            scramble_segs();
            for (int i = 0; i < SEG_SLOTS; i++)
               seg_buf[i].dur = '0;
            offer_item(REQ_START, now_ms_cur);
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off on request
   // ------------------------------------------------------------------
   initial begin : receiver
      int hold_count;
      hold_count = 0;
      hold_taken = 1'b0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_count = HOLD_CYCLES;
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 26);
         end
      end
   end

   // watchdog: nothing accepted on either side for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      int target;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_type     = REQ_TICK;
      req_now_ms   = '0;
      req_freq_a   = '0;
      req_dur_a    = '0;
      req_freq_b   = '0;
      req_dur_b    = '0;
      req_freq_c   = '0;
      req_dur_c    = '0;
      req_freq_d   = '0;
      req_dur_d    = '0;
      req_freq_e   = '0;
      req_dur_e    = '0;
      calm         = 1'b0;
      hold_req     = 1'b0;
      now_ms_cur   = '0;
      items_sent   = 0;
      set_segs(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed opening ---
      send_tick(32'd0);                              // idle tick
      set_segs(1000, 0, 2000, 0, 3000, 0, 4000, 0, 5000, 0);
      offer_item(REQ_START, 32'd50);                 // every duration zero
      send_tick(32'd60);                             // still idle
      set_segs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      offer_item(REQ_START, 32'd0);                  // full-scale list
      send_tick(32'h0000_FFFE);                      // one short of deadline
      send_tick(32'h0000_FFFF);                      // exactly due
      // restart mid-play: silence, zero-length tone and silence, tone, length 4
      set_segs(0, 5, 1, 0, 0, 0, 2, 3, 7, 0);
      offer_item(REQ_START, 32'd100);
      send_tick(32'd105);
      send_tick(32'd105);
      send_tick(32'd105);
      send_tick(32'd107);                            // early
      send_tick(32'd108);                            // release
      send_tick(32'd200);                            // idle after release
      // deadline wraps past 2^32 and falls due at once
      set_segs(440, 16'h0020, 0, 0, 0, 0, 0, 0, 880, 1);
      offer_item(REQ_START, 32'hFFFF_FFF0);
      send_tick(32'hFFFF_FFF1);
      send_tick(32'hFFFF_FFFF);
      send_tick(32'hFFFF_FFFF);
      send_tick(32'hFFFF_FFFF);                      // last tone, deadline 0
      send_tick(32'd0);                              // release
      // empty list stops a list that is playing
      set_segs(300, 1, 0, 0, 0, 0, 0, 0, 0, 0);
      offer_item(REQ_START, 32'd10);
      set_segs(16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 0);
      offer_item(REQ_START, 32'd10);
      send_tick(32'hFFFF_FFFF);
      pause_until_drained();

      // --- random part ---
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if (items_sent > target - 900 && items_sent < target - 650)
            calm = 1'b1;                              // back-to-back stretch
         else
            calm = 1'b0;
         if (!hold_req && items_sent > target - 450) begin
            // receiver holds off while starts keep coming: the block fills
            // and stalls its input; then wait for everything to drain
            hold_req = 1'b1;
            repeat (30) begin
               scramble_segs();
               seg_buf[0].dur = 16'($urandom_range(1, 16'hFFFF));
               offer_item(REQ_START, now_ms_cur);
            end
            pause_until_drained();
         end
         if ($urandom_range(0, 4) != 0)
            play_random_sequence();
         else
            inject_noise();
      end

      pause_until_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/tss_pkg.sv
rtl/core/tss_cell.sv
rtl/core/tone_segment_sequencer.sv
rtl/core/tss_checker.sv
tb/sv/tone_sequence_checker.sv
tb/sv/testbench.sv
